// ----- hw/rtl/hba_pkg.sv -----
// ----------------------------------------------------------------------------
// hba_pkg
// Shared types and constants for the histogram bin accumulator: bin table
// geometry, operation and status codes, controller state and the command
// and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package hba_pkg;

   localparam int NUM_BINS = 64;
   localparam int BIN_W    = $clog2(NUM_BINS);
   localparam int BINS_W   = BIN_W + 1;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 32;
   localparam int SUM_W    = 64;
   localparam int ACC_W    = SUM_W + CNT_W;
   localparam int CFG_W    = 7;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOAD   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_BINS = 2'd1,
      STATUS_BELOW   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_REPORT = 2'd2
   } state_type;

   typedef enum logic [2:0] {
      POST_INSERT = 3'd0,
      POST_MISS   = 3'd1,
      POST_EMPTY  = 3'd2,
      POST_LOAD   = 3'd3,
      POST_CLEAR  = 3'd4,
      POST_READ   = 3'd5
   } post_type;

   typedef struct packed {
      logic     accept;
      logic     step;
      logic     post;
      post_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic   search_done;
      logic   edge_le;
      logic   out_free;
      logic   bins_zero;
      op_type op;
   } dp_status_type;

endpackage

// ----- hw/rtl/hba_ram.sv -----
// ----------------------------------------------------------------------------
// hba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/hba_ctrl.sv -----
// ----------------------------------------------------------------------------
// hba_ctrl
// Controller: takes requests, runs the binary search one probe per cycle
// and decides when and how the datapath posts a result.
// ----------------------------------------------------------------------------
module hba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_operation,
   output logic                  req_stall,
   input  hba_pkg::dp_status_type st,
   output hba_pkg::dp_cmd_type   cmd
);

   hba_pkg::state_type state_ff;
   hba_pkg::state_type state_in;
   hba_pkg::op_type    req_op;

   assign req_op = hba_pkg::op_type'(req_operation);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hba_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hba_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == hba_pkg::OP_INSERT && !st.bins_zero) begin
                  state_in = hba_pkg::ST_SEARCH;
               end else begin
                  state_in = hba_pkg::ST_REPORT;
               end
            end
         end
         hba_pkg::ST_SEARCH: begin
            if (st.search_done && st.out_free) begin
               state_in = hba_pkg::ST_IDLE;
            end
         end
         hba_pkg::ST_REPORT: begin
            if (st.out_free) begin
               state_in = hba_pkg::ST_IDLE;
            end
         end
         default: state_in = hba_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall  = 1'b1;
      cmd.accept = 1'b0;
      cmd.step   = 1'b0;
      cmd.post   = 1'b0;
      cmd.kind   = hba_pkg::POST_READ;
      case (state_ff)
         hba_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         hba_pkg::ST_SEARCH: begin
            if (!st.search_done) begin
               cmd.step = 1'b1;
            end else begin
               cmd.post = st.out_free;
               cmd.kind = st.edge_le ? hba_pkg::POST_INSERT : hba_pkg::POST_MISS;
            end
         end
         hba_pkg::ST_REPORT: begin
            cmd.post = st.out_free;
            case (st.op)
               hba_pkg::OP_INSERT: cmd.kind = hba_pkg::POST_EMPTY;
               hba_pkg::OP_LOAD:   cmd.kind = hba_pkg::POST_LOAD;
               hba_pkg::OP_CLEAR:  cmd.kind = hba_pkg::POST_CLEAR;
               default:            cmd.kind = hba_pkg::POST_READ;
            endcase
         end
         default: req_stall = 1'b1;
      endcase
   end

   a_post_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> st.out_free)
      else $error("result posted while output register is held");

   a_search_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hba_pkg::ST_SEARCH && cmd.post) |=> state_ff == hba_pkg::ST_IDLE)
      else $error("controller did not return to idle after insert");

endmodule

// ----- hw/rtl/hba_dpath.sv -----
// ----------------------------------------------------------------------------
// hba_dpath
// Datapath: edge and accumulator RAMs, search bounds, running totals and
// the result register.
// ----------------------------------------------------------------------------
module hba_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  hba_pkg::dp_cmd_type                 cmd,
   output hba_pkg::dp_status_type              st,
   input  logic [hba_pkg::CFG_W-1:0]           bins_in_use,
   input  logic [1:0]                          req_operation,
   input  logic signed [hba_pkg::DATA_W-1:0]   req_sample,
   input  logic [hba_pkg::BIN_W-1:0]           req_bin_index,
   input  logic signed [hba_pkg::DATA_W-1:0]   req_bound_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [hba_pkg::BIN_W-1:0]           rsp_found_bin,
   output logic [hba_pkg::CNT_W-1:0]           rsp_bin_count,
   output logic signed [hba_pkg::SUM_W-1:0]    rsp_bin_sum,
   output logic signed [hba_pkg::DATA_W-1:0]   rsp_bin_edge,
   output logic [hba_pkg::CNT_W-1:0]           rsp_total_count,
   output logic signed [hba_pkg::SUM_W-1:0]    rsp_total_sum
);

   localparam int BIN_W  = hba_pkg::BIN_W;
   localparam int BINS_W = hba_pkg::BINS_W;
   localparam int CNT_W  = hba_pkg::CNT_W;
   localparam int SUM_W  = hba_pkg::SUM_W;
   localparam int DATA_W = hba_pkg::DATA_W;

   // captured request
   hba_pkg::op_type           op_ff;
   logic signed [DATA_W-1:0]  sample_ff;
   logic [BIN_W-1:0]          idx_ff;
   logic signed [DATA_W-1:0]  bound_ff;

   // search bounds; mid_ff is the address behind the current RAM data
   logic [BIN_W-1:0]  lo_ff, lo_in;
   logic [BINS_W-1:0] hi_ff, hi_in;
   logic [BIN_W-1:0]  mid_ff, mid_in;
   logic [BINS_W-1:0] mid_sum;
   logic [BINS_W-1:0] bins_n;

   logic [hba_pkg::NUM_BINS-1:0] acc_valid_ff;
   logic [CNT_W-1:0]             total_count_ff, total_count_in;
   logic signed [SUM_W-1:0]      total_sum_ff, total_sum_in;

   logic                         rsp_valid_ff;
   hba_pkg::status_type          rsp_status_ff;
   logic [BIN_W-1:0]             rsp_found_bin_ff;
   logic [CNT_W-1:0]             rsp_bin_count_ff;
   logic signed [SUM_W-1:0]      rsp_bin_sum_ff;
   logic signed [DATA_W-1:0]     rsp_bin_edge_ff;

   logic [DATA_W-1:0]            edge_rd;
   logic [hba_pkg::ACC_W-1:0]    acc_rd;
   logic                         edge_le;
   logic [CNT_W-1:0]             cnt_cur, cnt_new;
   logic signed [SUM_W-1:0]      sum_cur, sum_new, sample_ext;
   logic                         cnt_sat;
   logic                         edge_we, acc_we;

   assign bins_n = (bins_in_use > BINS_W'(hba_pkg::NUM_BINS))
                   ? BINS_W'(hba_pkg::NUM_BINS) : bins_in_use[BINS_W-1:0];

   assign edge_le = $signed(edge_rd) <= sample_ff;

   // one probe: keep the upper or lower half
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.accept) begin
         lo_in = '0;
         hi_in = bins_n;
      end else if (cmd.step) begin
         if (edge_le) begin
            lo_in = mid_ff;
         end else begin
            hi_in = {1'b0, mid_ff};
         end
      end
   end

   assign mid_sum = {1'b0, lo_in} + hi_in;

   always_comb begin
      mid_in = mid_ff;
      if (cmd.accept) begin
         if (hba_pkg::op_type'(req_operation) == hba_pkg::OP_INSERT) begin
            mid_in = bins_n[BINS_W-1:1];
         end else begin
            mid_in = req_bin_index;
         end
      end else if (cmd.step) begin
         mid_in = mid_sum[BINS_W-1:1];
      end
   end

   assign edge_we = cmd.post && cmd.kind == hba_pkg::POST_LOAD;
   assign acc_we  = cmd.post && cmd.kind == hba_pkg::POST_INSERT;

   hba_ram #(.WIDTH(DATA_W), .DEPTH(hba_pkg::NUM_BINS)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (idx_ff),
      .wr_data (bound_ff),
      .rd_addr (mid_in),
      .rd_data (edge_rd)
   );

   hba_ram #(.WIDTH(hba_pkg::ACC_W), .DEPTH(hba_pkg::NUM_BINS)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_we),
      .wr_addr (mid_ff),
      .wr_data ({sum_new, cnt_new}),
      .rd_addr (mid_in),
      .rd_data (acc_rd)
   );

   // entries never written since reset or clear read as zero
   assign cnt_cur    = acc_valid_ff[mid_ff] ? acc_rd[CNT_W-1:0] : '0;
   assign sum_cur    = acc_valid_ff[mid_ff] ? $signed(acc_rd[hba_pkg::ACC_W-1:CNT_W]) : '0;
   assign sample_ext = SUM_W'(sample_ff);
   assign cnt_sat    = &cnt_cur;
   assign cnt_new    = cnt_sat ? cnt_cur : cnt_cur + 1'b1;
   assign sum_new    = sum_cur + sample_ext;

   always_comb begin
      total_count_in = total_count_ff;
      total_sum_in   = total_sum_ff;
      if (cmd.post && cmd.kind == hba_pkg::POST_CLEAR) begin
         total_count_in = '0;
         total_sum_in   = '0;
      end else if (acc_we) begin
         if (!cnt_sat && !(&total_count_ff)) begin
            total_count_in = total_count_ff + 1'b1;
         end
         total_sum_in = total_sum_ff + sample_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff   <= '0;
         total_count_ff <= '0;
         total_sum_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         total_count_ff <= total_count_in;
         total_sum_ff   <= total_sum_in;
         if (cmd.post && cmd.kind == hba_pkg::POST_CLEAR) begin
            acc_valid_ff <= '0;
         end else if (acc_we) begin
            acc_valid_ff[mid_ff] <= 1'b1;
         end
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      if (cmd.accept) begin
         op_ff     <= hba_pkg::op_type'(req_operation);
         sample_ff <= req_sample;
         idx_ff    <= req_bin_index;
         bound_ff  <= req_bound_value;
      end
      if (cmd.post) begin
         rsp_status_ff    <= hba_pkg::STATUS_OK;
         rsp_found_bin_ff <= '0;
         rsp_bin_count_ff <= '0;
         rsp_bin_sum_ff   <= '0;
         rsp_bin_edge_ff  <= '0;
         case (cmd.kind)
            hba_pkg::POST_INSERT: begin
               rsp_found_bin_ff <= mid_ff;
               rsp_bin_count_ff <= cnt_new;
               rsp_bin_sum_ff   <= sum_new;
               rsp_bin_edge_ff  <= edge_rd;
            end
            hba_pkg::POST_MISS:  rsp_status_ff <= hba_pkg::STATUS_BELOW;
            hba_pkg::POST_EMPTY: rsp_status_ff <= hba_pkg::STATUS_NO_BINS;
            hba_pkg::POST_LOAD: begin
               rsp_found_bin_ff <= mid_ff;
               rsp_bin_count_ff <= cnt_cur;
               rsp_bin_sum_ff   <= sum_cur;
               rsp_bin_edge_ff  <= bound_ff;
            end
            hba_pkg::POST_READ: begin
               rsp_found_bin_ff <= mid_ff;
               rsp_bin_count_ff <= cnt_cur;
               rsp_bin_sum_ff   <= sum_cur;
               rsp_bin_edge_ff  <= edge_rd;
            end
            default: rsp_status_ff <= hba_pkg::STATUS_OK;
         endcase
      end
   end

   assign st.search_done = ({1'b0, lo_ff} + 1'b1) == hi_ff;
   assign st.edge_le     = edge_le;
   assign st.out_free    = !rsp_valid_ff || !rsp_stall;
   assign st.bins_zero   = bins_in_use == '0;
   assign st.op          = op_ff;

   // totals only move on a post, which waits for a free output slot,
   // so the live registers match the held result
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_bin   = rsp_found_bin_ff;
   assign rsp_bin_count   = rsp_bin_count_ff;
   assign rsp_bin_sum     = rsp_bin_sum_ff;
   assign rsp_bin_edge    = rsp_bin_edge_ff;
   assign rsp_total_count = total_count_ff;
   assign rsp_total_sum   = total_sum_ff;

   a_step_open_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ({1'b0, lo_ff} + 1'b1) < hi_ff)
      else $error("search probe with an empty range");

   a_clear_zeroes_totals: assert property (@(posedge clock) disable iff (reset)
      (cmd.post && cmd.kind == hba_pkg::POST_CLEAR)
      |=> (total_count_ff == '0 && total_sum_ff == '0 && acc_valid_ff == '0))
      else $error("clear left accumulated state");

endmodule

// ----- hw/rtl/histogram_bin_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// histogram_bin_accumulator_top
// Variable-width histogram: binary search over loaded lower edges, then
// count and sum update of the chosen bin, with running totals.
// ----------------------------------------------------------------------------
// One request is in work at a time; a new one is taken while the previous
// result still sits in the output register. An insert searches the edge
// RAM with p probes: floor or ceil of log2(n) depending on the path, for
// n = min(bins_in_use, 64) loaded bins, so six probes with all 64 bins in
// use; the search does one registered edge-RAM read per probe and the
// bin's count and sum update with one read-modify-write of the accumulator
// RAM. Load, read, clear and inserts with no bins skip the search. A held
// result delays the next post, and so the acceptance after it. Counts and
// sums start at zero after reset with no clearing pass; clear empties every
// bin at once. Edges are undefined until loaded, and bins_in_use above 64
// behaves as 64.
// ----------------------------------------------------------------------------
module histogram_bin_accumulator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_operation,
   input  logic signed [hba_pkg::DATA_W-1:0]   req_sample,
   input  logic [hba_pkg::BIN_W-1:0]           req_bin_index,
   input  logic signed [hba_pkg::DATA_W-1:0]   req_bound_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [hba_pkg::BIN_W-1:0]           rsp_found_bin,
   output logic [hba_pkg::CNT_W-1:0]           rsp_bin_count,
   output logic signed [hba_pkg::SUM_W-1:0]    rsp_bin_sum,
   output logic signed [hba_pkg::DATA_W-1:0]   rsp_bin_edge,
   output logic [hba_pkg::CNT_W-1:0]           rsp_total_count,
   output logic signed [hba_pkg::SUM_W-1:0]    rsp_total_sum,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   logic [hba_pkg::CFG_W-1:0] bins_in_use_ff;
   logic                      csr_hit;
   hba_pkg::dp_cmd_type       cmd;
   hba_pkg::dp_status_type    st;

   // single register, decoded at offsets zero to three
   assign csr_hit    = !csr_paddr[2];
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(32 - hba_pkg::CFG_W){1'b0}}, bins_in_use_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_in_use_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         bins_in_use_ff <= csr_pwdata[hba_pkg::CFG_W-1:0];
      end
   end

   hba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .st            (st),
      .cmd           (cmd)
   );

   hba_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .bins_in_use     (bins_in_use_ff),
      .req_operation   (req_operation),
      .req_sample      (req_sample),
      .req_bin_index   (req_bin_index),
      .req_bound_value (req_bound_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found_bin   (rsp_found_bin),
      .rsp_bin_count   (rsp_bin_count),
      .rsp_bin_sum     (rsp_bin_sum),
      .rsp_bin_edge    (rsp_bin_edge),
      .rsp_total_count (rsp_total_count),
      .rsp_total_sum   (rsp_total_sum)
   );

endmodule

// ----- sim/histogram_bin_accumulator_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_bin_accumulator_checker
// Watches the request, result and register ports of the histogram bin
// accumulator. Keeps its own copy of the bin tables, predicts the result of
// every accepted request and compares it field by field, in order.
// ----------------------------------------------------------------------------
module histogram_bin_accumulator_checker
   import hba_pkg::*;
#(
   parameter logic [2:0] BINS_ADDR = 3'd0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic signed [DATA_W-1:0]  req_sample,
   input  logic [BIN_W-1:0]          req_bin_index,
   input  logic signed [DATA_W-1:0]  req_bound_value,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_status,
   input  logic [BIN_W-1:0]          rsp_found_bin,
   input  logic [CNT_W-1:0]          rsp_bin_count,
   input  logic signed [SUM_W-1:0]   rsp_bin_sum,
   input  logic signed [DATA_W-1:0]  rsp_bin_edge,
   input  logic [CNT_W-1:0]          rsp_total_count,
   input  logic signed [SUM_W-1:0]   rsp_total_sum,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   input  logic [31:0]               csr_prdata,
   input  logic                      csr_pready,
   output int                        fail_count,
   output int                        pending,
   output int                        checked
);

   typedef struct {
      status_type               status;
      logic [BIN_W-1:0]         found_bin;
      logic [CNT_W-1:0]         bin_count;
      logic signed [SUM_W-1:0]  bin_sum;
      logic signed [DATA_W-1:0] bin_edge;
      logic [CNT_W-1:0]         total_count;
      logic signed [SUM_W-1:0]  all_bins_sum;
   } bin_result_t;

   logic signed [DATA_W-1:0] lower_edges [NUM_BINS];
   logic [CNT_W-1:0]         bin_counts  [NUM_BINS];
   logic signed [SUM_W-1:0]  bin_sums    [NUM_BINS];
   logic [CNT_W-1:0]         all_count;
   logic signed [SUM_W-1:0]  all_sum;
   logic [CFG_W-1:0]         bins_active;
   bin_result_t              awaited_results [$];

   function automatic bin_result_t bin_snapshot(status_type st, int bin, bit have_bin);
      bin_result_t r;
      r.status       = st;
      r.total_count  = all_count;
      r.all_bins_sum = all_sum;
      if (have_bin) begin
         r.found_bin = bin[BIN_W-1:0];
         r.bin_count = bin_counts[bin];
         r.bin_sum   = bin_sums[bin];
         r.bin_edge  = lower_edges[bin];
      end else begin
         r.found_bin = '0;
         r.bin_count = '0;
         r.bin_sum   = '0;
         r.bin_edge  = '0;
      end
      return r;
   endfunction

   function automatic bin_result_t bin_update(op_type op, logic signed [DATA_W-1:0] smp,
                                              logic [BIN_W-1:0] idx,
                                              logic signed [DATA_W-1:0] bnd);
      int n;
      int lo;
      int hi;
      int mid;
      n = (bins_active > NUM_BINS) ? NUM_BINS : int'(bins_active);
      case (op)
         OP_INSERT: begin
            if (n == 0) return bin_snapshot(STATUS_NO_BINS, 0, 1'b0);
            lo = 0;
            hi = n;
            // last bin whose lower edge is at most the sample
            while (lo + 1 < hi) begin
               mid = (lo + hi) / 2;
               if (lower_edges[mid] <= smp) lo = mid;
               else hi = mid;
            end
            if (!(lower_edges[lo] <= smp)) return bin_snapshot(STATUS_BELOW, 0, 1'b0);
            // the total only moves when the bin count moves
            if (bin_counts[lo] != '1) begin
               bin_counts[lo] = bin_counts[lo] + 1'b1;
               if (all_count != '1) all_count = all_count + 1'b1;
            end
            bin_sums[lo] = bin_sums[lo] + {{(SUM_W-DATA_W){smp[DATA_W-1]}}, smp};
            all_sum      = all_sum + {{(SUM_W-DATA_W){smp[DATA_W-1]}}, smp};
            return bin_snapshot(STATUS_OK, lo, 1'b1);
         end
         OP_LOAD: begin
            lower_edges[idx] = bnd;
            return bin_snapshot(STATUS_OK, idx, 1'b1);
         end
         OP_CLEAR: begin
            for (int k = 0; k < NUM_BINS; k++) begin
               bin_counts[k] = '0;
               bin_sums[k]   = '0;
            end
            all_count = '0;
            all_sum   = '0;
            return bin_snapshot(STATUS_OK, 0, 1'b0);
         end
         default: return bin_snapshot(STATUS_OK, idx, 1'b1);
      endcase
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      bin_result_t want;
      if (reset) begin
         for (int k = 0; k < NUM_BINS; k++) begin
            bin_counts[k] = '0;
            bin_sums[k]   = '0;
         end
         all_count   = '0;
         all_sum     = '0;
         bins_active = '0;
         fail_count  = 0;
         checked     = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               fail_count++;
               $display("%0t: result with no request waiting, expected none actual status %h bin %h",
                        $time, rsp_status, rsp_found_bin);
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_status));
               compare_field("found_bin", 64'(want.found_bin), 64'(rsp_found_bin));
               compare_field("bin_count", 64'(want.bin_count), 64'(rsp_bin_count));
               compare_field("bin_sum", want.bin_sum, rsp_bin_sum);
               compare_field("bin_edge", 64'(want.bin_edge), 64'(rsp_bin_edge));
               compare_field("total_count", 64'(want.total_count), 64'(rsp_total_count));
               compare_field("sum over all bins", want.all_bins_sum, rsp_total_sum);
               checked++;
            end
         end
         if (req_valid && !req_stall)
            awaited_results.insert(awaited_results.size(),
                                   bin_update(op_type'(req_operation), req_sample,
                                              req_bin_index, req_bound_value));
         if (csr_psel && csr_penable && csr_pready && csr_paddr == BINS_ADDR) begin
            if (csr_pwrite) bins_active = csr_pwdata[CFG_W-1:0];
            else compare_field("bins_in_use readback", 64'(bins_active),
                               64'(csr_prdata));
         end
      end
      pending <= awaited_results.size();
   end

endmodule

// ----- sim/histogram_bin_accumulator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_bin_accumulator_top_tb
// Drives the histogram bin accumulator with directed requests and then with
// phases of bin edge sets and mixed requests under several bins_in_use
// settings, with random idling on both sides and one long result hold.
// ----------------------------------------------------------------------------
module histogram_bin_accumulator_top_tb;
   import hba_pkg::*;

   localparam logic [2:0] CSR_BINS_IN_USE = 3'd0;
   localparam int RANDOM_ITEMS  = 650;
   localparam int QUIET_TAIL    = 100;
   localparam int LONG_HOLD     = 80;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 5000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_operation;
   logic signed [DATA_W-1:0]  req_sample;
   logic [BIN_W-1:0]          req_bin_index;
   logic signed [DATA_W-1:0]  req_bound_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [BIN_W-1:0]          rsp_found_bin;
   logic [CNT_W-1:0]          rsp_bin_count;
   logic signed [SUM_W-1:0]   rsp_bin_sum;
   logic signed [DATA_W-1:0]  rsp_bin_edge;
   logic [CNT_W-1:0]          rsp_total_count;
   logic signed [SUM_W-1:0]   rsp_total_sum;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [2:0]                csr_paddr;
   logic [31:0]               csr_pwdata;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int pending;
   int checked;

   bit tail_quiet;
   bit hold_request;
   bit sender_gappy;
   int sent;
   logic signed [DATA_W-1:0] edge_copy [NUM_BINS];
   bit edge_set [NUM_BINS];

   always #1 clock = ~clock;

   histogram_bin_accumulator_top i_dut (.*);

   histogram_bin_accumulator_checker #(.BINS_ADDR(CSR_BINS_IN_USE)) i_checker (.*);

   task automatic send_request(op_type op, logic signed [DATA_W-1:0] smp,
                               logic [BIN_W-1:0] idx, logic signed [DATA_W-1:0] bnd);
      if (sender_gappy && !tail_quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_sample      <= smp;
      req_bin_index   <= idx;
      req_bound_value <= bnd;
      do @(posedge clock); while (req_stall);
      sent++;
      if (op == OP_LOAD) begin
         edge_copy[idx] = bnd;
         edge_set[idx]  = 1'b1;
      end
   endtask

   task automatic insert_sample(logic signed [DATA_W-1:0] smp);
      send_request(OP_INSERT, smp, BIN_W'($urandom), $urandom);
   endtask

   task automatic load_edge(logic [BIN_W-1:0] idx, logic signed [DATA_W-1:0] bnd);
      send_request(OP_LOAD, $urandom, idx, bnd);
   endtask

   task automatic read_bin(logic [BIN_W-1:0] idx);
      send_request(OP_READ, $urandom, idx, $urandom);
   endtask

   task automatic clear_bins();
      send_request(OP_CLEAR, $urandom, BIN_W'($urandom), $urandom);
   endtask

   // sender stops and waits until every result is back and the block is idle
   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         guard++;
      end while (pending != 0 && guard < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(bit wr, logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_bins_in_use(int n);
      wait_drained();
      csr_access(1'b1, CSR_BINS_IN_USE, 32'(n));
      csr_access(1'b0, CSR_BINS_IN_USE, 32'd0);
   endtask

   // samples cluster around loaded edges, with some fully random and extremes
   function automatic logic signed [DATA_W-1:0] pick_sample(int m);
      int choice;
      longint base;
      choice = $urandom_range(0, 9);
      if (m == 0 || choice < 2) return $urandom;
      if (choice == 2) return ($urandom_range(0, 1) == 1) ? 32'h7fffffff : 32'h80000000;
      base = edge_copy[$urandom_range(0, m - 1)];
      if (choice < 7) base = base + $urandom_range(0, 4) - 2;
      else if (choice < 9) base = base + $urandom_range(0, 32'h100000);
      else base = base - $urandom_range(1, 32'h100000);
      return base[31:0];
   endfunction

   // sorted with close or repeated edges, spread over the full range, or shuffled
   task automatic load_edge_set(int m);
      int style;
      longint level;
      style = $urandom_range(0, 9);
      level = (style < 5) ? longint'(int'($urandom)) / 2 : -64'sd2147483648;
      for (int i = 0; i < m; i++) begin
         if (style >= 8) begin
            load_edge(BIN_W'(i), $urandom);
         end else if (style >= 5) begin
            load_edge(BIN_W'(i),
                      32'(level + i * (64'sd4294967296 / m) + $urandom_range(0, 255)));
         end else begin
            load_edge(BIN_W'(i), level[31:0]);
            level += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h100000);
         end
      end
   endtask

   // result side: short stall bursts, calm stretches, one long hold on demand
   initial begin
      int calm_left;
      calm_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
         end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 63) == 0) begin
            calm_left = $urandom_range(40, 120);
         end
      end
   end

   initial begin
      int plan [6];
      int total;
      int phase;
      int n;
      int m;
      int ops;
      int r;
      int k;
      plan            = '{1, 64, 2, 127, 0, 64};
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_operation   <= OP_INSERT;
      req_sample      <= '0;
      req_bin_index   <= '0;
      req_bound_value <= '0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= '0;
      csr_pwdata      <= '0;
      sender_gappy = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // no bins in use yet
      insert_sample(32'h7fffffff);
      set_bins_in_use(4);
      load_edge(0, 32'hffff0000);
      load_edge(1, 32'h00000000);
      load_edge(2, 32'h00010000);
      load_edge(3, 32'h7fffffff);
      insert_sample(32'h80000000);
      insert_sample(32'hfffeffff);
      insert_sample(32'hffff0000);
      insert_sample(32'h00000000);
      insert_sample(32'h0000ffff);
      insert_sample(32'h00010000);
      insert_sample(32'h7ffffffe);
      insert_sample(32'h7fffffff);
      read_bin(2);
      // bin outside the searched range
      load_edge(63, 32'h80000000);
      read_bin(63);
      clear_bins();
      read_bin(2);
      insert_sample(32'h00012345);
      // duplicate edges: the last of the equal ones takes the sample
      load_edge(2, 32'h00000000);
      insert_sample(32'h00000000);

      total = sent + RANDOM_ITEMS;
      phase = 0;
      while (sent < total) begin
         if (phase < 6) n = plan[phase];
         else if ($urandom_range(0, 15) == 0) n = 0;
         else if ($urandom_range(0, 7) == 0) n = $urandom_range(65, 127);
         else n = $urandom_range(1, 64);
         set_bins_in_use(n);
         m = (n > NUM_BINS) ? NUM_BINS : n;
         if (m > 0) load_edge_set(m);
         sender_gappy = ($urandom_range(0, 1) == 1);
         if (phase == 1) begin
            sender_gappy = 1'b0;
            hold_request = 1'b1;
         end
         ops = (m == 0) ? 12 : $urandom_range(30, 70);
         for (int i = 0; i < ops && sent < total; i++) begin
            if (sent >= total - QUIET_TAIL) tail_quiet = 1'b1;
            r = $urandom_range(0, 99);
            k = $urandom_range(0, NUM_BINS - 1);
            if (r < 70) begin
               insert_sample(pick_sample(m));
            end else if (r < 82) begin
               if (!edge_set[k]) k = 0;
               read_bin(BIN_W'(k));
            end else if (r < 96) begin
               if (k < m && $urandom_range(0, 2) != 0) load_edge(BIN_W'(k), edge_copy[k]);
               else load_edge(BIN_W'(k), $urandom);
            end else begin
               clear_bins();
            end
         end
         phase++;
      end

      wait_drained();
      $display("covered %0d requests over %0d bins_in_use settings, %0d results compared",
               sent, phase + 1, checked);
      $display("edge sets sorted, spread, repeated and shuffled; one long result hold");
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/hba_pkg.sv
hw/rtl/hba_ram.sv
hw/rtl/hba_ctrl.sv
hw/rtl/hba_dpath.sv
hw/rtl/histogram_bin_accumulator_top.sv
sim/histogram_bin_accumulator_checker.sv
sim/histogram_bin_accumulator_top_tb.sv
